/* hw/rtl/assert_macros.svh */
// assertion macros for the rtl of the state update sync checker
// no dependencies; included by the top level, the one file that carries concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every rising edge, muted while reset is asserted
`define SUSC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every rising edge, reset included
`define SUSC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/susc_pkg.sv */
// types and codes of the state update sync checker
// no dependencies; used by the channel interfaces and the top level
`default_nettype none

package susc_pkg;

  localparam int unsigned SessW   = 32;
  localparam int unsigned SeqW    = 32;
  localparam int unsigned RevW    = 32;
  localparam int unsigned StampW  = 64;
  localparam int unsigned TimeW   = 48;
  localparam int unsigned TimeoutW = 32;

  localparam logic [TimeoutW-1:0] TimeoutReset = 32'd1000000;

  typedef enum logic [1:0] {
    CMD_UPDATE = 2'd0,
    CMD_POLL   = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_SPARE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_SNAPSHOT  = 2'd0,
    KIND_DELTA     = 2'd1,
    KIND_HEARTBEAT = 2'd2,
    KIND_SPARE     = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    V_SNAPSHOT       = 4'd0,
    V_DELTA          = 4'd1,
    V_HEARTBEAT      = 4'd2,
    V_DUPLICATE      = 4'd3,
    V_STALE          = 4'd4,
    V_NEEDS_SNAPSHOT = 4'd5,
    V_GAP            = 4'd6,
    V_REV_MISMATCH   = 4'd7,
    V_NONE           = 4'd8
  } verdict_e;

endpackage

`default_nettype wire

/* hw/rtl/susc_in_if.sv */
// input channel of the state update sync checker: valid, ready and update fields
// depends on susc_pkg for field widths
`default_nettype none

interface susc_in_if import susc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        cmd;
  logic [1:0]        kind;
  logic [SessW-1:0]  session_tag;
  logic [SeqW-1:0]   seq_number;
  logic [RevW-1:0]   new_revision;
  logic [RevW-1:0]   prior_revision;
  logic [StampW-1:0] stamp_us;
  logic [TimeW-1:0]  now_us;

  modport source (
    output valid, cmd, kind, session_tag, seq_number, new_revision,
           prior_revision, stamp_us, now_us,
    input  ready
  );

  modport sink (
    input  valid, cmd, kind, session_tag, seq_number, new_revision,
           prior_revision, stamp_us, now_us,
    output ready
  );
endinterface

`default_nettype wire

/* hw/rtl/susc_out_if.sv */
// result channel of the state update sync checker: valid, ready and verdict fields
// depends on susc_pkg
`default_nettype none

interface susc_out_if import susc_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [3:0] verdict;
  logic       link_lost;
  logic       in_sync;
  logic       resync_needed;

  modport source (
    output valid, verdict, link_lost, in_sync, resync_needed,
    input  ready
  );

  modport sink (
    input  valid, verdict, link_lost, in_sync, resync_needed,
    output ready
  );
endinterface

`default_nettype wire

/* hw/rtl/state_update_sync_checker.sv */
// top level of the state update sync checker: tracking state, verdict logic, result register
// depends on susc_pkg, susc_in_if, susc_out_if and assert_macros.svh
`default_nettype none

//  channel   direction  handshake            payload
//  in_i      sink       valid / ready        cmd kind session_tag seq_number
//                                            new_revision prior_revision stamp_us now_us
//  out_o     source     valid / ready        verdict link_lost in_sync resync_needed
//  cfg       write      cfg_we_i             cfg_wdata_i -> timeout_us
//
//  one transaction per cycle in each direction while results are taken, one result per
//  input transaction, delivered in the cycle after acceptance; the rate is set by the
//  single state register update, whose next value comes from one pass of compare logic
//  reset clears the tracking state, sets the resync flag and loads the default timeout
//  a stalled result holds in the output register; a new transaction is taken in the
//  same cycle that the held result is taken

`include "assert_macros.svh"

module state_update_sync_checker import susc_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [TimeoutW-1:0] cfg_wdata_i,
  susc_in_if.sink                  in_i,
  susc_out_if.source               out_o
);

  // configuration
  logic [TimeoutW-1:0] timeout_q;

  // tracking state
  logic              sess_valid_q, sess_valid_d;
  logic [SessW-1:0]  cur_sess_q, cur_sess_d;
  logic [SeqW-1:0]   last_seq_q, last_seq_d;
  logic [RevW-1:0]   last_rev_q, last_rev_d;
  logic [StampW-1:0] last_stamp_q, last_stamp_d;
  logic              synced_q, synced_d;
  logic              resync_q, resync_d;
  logic              heard_valid_q, heard_valid_d;
  logic [TimeW-1:0]  heard_time_q, heard_time_d;

  // result register
  logic       out_valid_q;
  verdict_e   verdict_q, verdict_d;
  logic       link_lost_q, link_lost_d;

  logic in_acc;
  logic new_sess;
  logic judge;
  logic base_sync;
  logic [SeqW-1:0] base_seq;
  logic [RevW-1:0] base_rev;
  logic [TimeW-1:0] silence;

  // output register frees up whenever the held result is taken
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_acc     = in_i.valid && in_i.ready;

  assign new_sess = !sess_valid_q || (cur_sess_q != in_i.session_tag);
  assign silence  = in_i.now_us - heard_time_q;

  always_comb begin
    sess_valid_d  = sess_valid_q;
    cur_sess_d    = cur_sess_q;
    last_seq_d    = last_seq_q;
    last_rev_d    = last_rev_q;
    last_stamp_d  = last_stamp_q;
    synced_d      = synced_q;
    resync_d      = resync_q;
    heard_valid_d = heard_valid_q;
    heard_time_d  = heard_time_q;
    verdict_d     = V_NONE;
    judge         = 1'b0;
    base_sync     = synced_q;
    base_seq      = last_seq_q;
    base_rev      = last_rev_q;

    case (cmd_e'(in_i.cmd))
      CMD_UPDATE: begin
        heard_valid_d = 1'b1;
        heard_time_d  = in_i.now_us;
        if (new_sess) begin
          // take the new session with freshly cleared history
          sess_valid_d = 1'b1;
          cur_sess_d   = in_i.session_tag;
          last_seq_d   = '0;
          last_rev_d   = '0;
          last_stamp_d = '0;
          synced_d     = 1'b0;
          resync_d     = 1'b1;
          base_sync    = 1'b0;
          base_seq     = '0;
          base_rev     = '0;
          if (kind_e'(in_i.kind) != KIND_SNAPSHOT) begin
            verdict_d = V_NEEDS_SNAPSHOT;
          end else begin
            judge = 1'b1;
          end
        end else if (in_i.seq_number == last_seq_q) begin
          verdict_d = V_DUPLICATE;
        end else if (in_i.seq_number < last_seq_q || in_i.stamp_us < last_stamp_q) begin
          verdict_d = V_STALE;
        end else begin
          judge = 1'b1;
        end

        if (judge) begin
          if (kind_e'(in_i.kind) == KIND_SNAPSHOT) begin
            last_seq_d   = in_i.seq_number;
            last_rev_d   = in_i.new_revision;
            last_stamp_d = in_i.stamp_us;
            synced_d     = 1'b1;
            resync_d     = 1'b0;
            verdict_d    = V_SNAPSHOT;
          end else if (!base_sync) begin
            resync_d  = 1'b1;
            verdict_d = V_NEEDS_SNAPSHOT;
          end else if (in_i.seq_number != base_seq + SeqW'(1)) begin
            // sequence increment wraps at the field width
            synced_d  = 1'b0;
            resync_d  = 1'b1;
            verdict_d = V_GAP;
          end else if (kind_e'(in_i.kind) == KIND_DELTA
                       && in_i.prior_revision != base_rev) begin
            synced_d  = 1'b0;
            resync_d  = 1'b1;
            verdict_d = V_REV_MISMATCH;
          end else begin
            last_seq_d   = in_i.seq_number;
            last_stamp_d = in_i.stamp_us;
            if (kind_e'(in_i.kind) == KIND_DELTA) begin
              last_rev_d = in_i.new_revision;
              verdict_d  = V_DELTA;
            end else begin
              // the spare kind code counts as a heartbeat
              verdict_d = V_HEARTBEAT;
            end
          end
        end
      end
      CMD_CLEAR: begin
        sess_valid_d  = 1'b0;
        cur_sess_d    = '0;
        last_seq_d    = '0;
        last_rev_d    = '0;
        last_stamp_d  = '0;
        synced_d      = 1'b0;
        resync_d      = 1'b1;
        heard_valid_d = 1'b0;
        heard_time_d  = '0;
      end
      default: begin
        // poll and the spare command only report
      end
    endcase
  end

  // link status after the transaction
  always_comb begin
    case (cmd_e'(in_i.cmd))
      CMD_UPDATE: link_lost_d = 1'b0;   // just heard, zero silence
      CMD_CLEAR:  link_lost_d = 1'b1;   // history gone, never heard
      default: begin
        if (!heard_valid_q) begin
          link_lost_d = 1'b1;
        end else if (in_i.now_us < heard_time_q) begin
          // local clock stepped back: treat as connected
          link_lost_d = 1'b0;
        end else begin
          link_lost_d = silence > {{(TimeW-TimeoutW){1'b0}}, timeout_q};
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q     <= TimeoutReset;
      sess_valid_q  <= 1'b0;
      cur_sess_q    <= '0;
      last_seq_q    <= '0;
      last_rev_q    <= '0;
      last_stamp_q  <= '0;
      synced_q      <= 1'b0;
      resync_q      <= 1'b1;
      heard_valid_q <= 1'b0;
      heard_time_q  <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
      if (in_acc) begin
        sess_valid_q  <= sess_valid_d;
        cur_sess_q    <= cur_sess_d;
        last_seq_q    <= last_seq_d;
        last_rev_q    <= last_rev_d;
        last_stamp_q  <= last_stamp_d;
        synced_q      <= synced_d;
        resync_q      <= resync_d;
        heard_valid_q <= heard_valid_d;
        heard_time_q  <= heard_time_d;
        out_valid_q   <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      verdict_q   <= verdict_d;
      link_lost_q <= link_lost_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.verdict       = verdict_q;
  assign out_o.link_lost     = link_lost_q;
  assign out_o.in_sync       = synced_q;
  assign out_o.resync_needed = resync_q;

  // synced and resync-required never coexist
  `SUSC_ASSERT_ALWAYS(a_sync_excl, clk_i, !(synced_q && resync_q), "synced with resync pending")

  // an applied snapshot always leaves the checker synchronized
  `SUSC_ASSERT(a_snap_synced, clk_i, rst_ni, (out_valid_q && verdict_q == V_SNAPSHOT) |-> synced_q, "snapshot verdict without sync")

  // a clear transaction wipes the session and the receive history
  `SUSC_ASSERT(a_clear_wipes, clk_i, rst_ni, (in_acc && in_i.cmd == CMD_CLEAR) |=> (!sess_valid_q && !heard_valid_q && link_lost_q), "clear left state behind")

  // an update transaction holds a session and counts as heard
  `SUSC_ASSERT(a_update_heard, clk_i, rst_ni, (in_acc && in_i.cmd == CMD_UPDATE) |=> (sess_valid_q && heard_valid_q && !link_lost_q), "update not recorded")

endmodule

`default_nettype wire

/* tb/susc_verdict_check.sv */
`timescale 1ns / 1ps
// predicts verdict, link status and sync flags for each accepted update and
// compares them with the result channel; depends on susc_pkg, susc_in_if, susc_out_if
module susc_verdict_check import susc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [TimeoutW-1:0] cfg_wdata_i,
  susc_in_if                  upd_mon,
  susc_out_if                 res_mon,
  output int unsigned         err_count_o,
  output int unsigned         pending_o
);

  typedef struct {
    verdict_e verdict;
    logic     link_lost;
    logic     in_sync;
    logic     resync_needed;
  } sync_result_t;

  sync_result_t        expected_q[$];

  logic [TimeoutW-1:0] timeout_us;
  logic                sess_held;
  logic [SessW-1:0]    cur_sess;
  logic [SeqW-1:0]     last_seq;
  logic [RevW-1:0]     last_rev;
  logic [StampW-1:0]   last_stamp;
  logic                synced;
  logic                resync;
  logic                heard;
  logic [TimeW-1:0]    heard_time;

  function automatic void clear_tracking();
    sess_held  = 1'b0;
    cur_sess   = '0;
    last_seq   = '0;
    last_rev   = '0;
    last_stamp = '0;
    synced     = 1'b0;
    resync     = 1'b1;
    heard      = 1'b0;
    heard_time = '0;
  endfunction

  function automatic verdict_e judge_update(input kind_e kind, input logic [SessW-1:0] sess,
                                            input logic [SeqW-1:0] seq,
                                            input logic [RevW-1:0] rev, base,
                                            input logic [StampW-1:0] stamp);
    if (!sess_held || cur_sess != sess) begin
      // new session: drop everything and wait for a snapshot
      sess_held  = 1'b1;
      cur_sess   = sess;
      last_seq   = '0;
      last_rev   = '0;
      last_stamp = '0;
      synced     = 1'b0;
      resync     = 1'b1;
      if (kind != KIND_SNAPSHOT) return V_NEEDS_SNAPSHOT;
    end else begin
      if (seq == last_seq) return V_DUPLICATE;
      if (seq < last_seq || stamp < last_stamp) return V_STALE;
    end
    if (kind == KIND_SNAPSHOT) begin
      last_seq   = seq;
      last_rev   = rev;
      last_stamp = stamp;
      synced     = 1'b1;
      resync     = 1'b0;
      return V_SNAPSHOT;
    end
    if (!synced) begin
      resync = 1'b1;
      return V_NEEDS_SNAPSHOT;
    end
    if (seq != SeqW'(last_seq + 1)) begin
      synced = 1'b0;
      resync = 1'b1;
      return V_GAP;
    end
    if (kind == KIND_DELTA && base != last_rev) begin
      synced = 1'b0;
      resync = 1'b1;
      return V_REV_MISMATCH;
    end
    last_seq   = seq;
    last_stamp = stamp;
    if (kind == KIND_DELTA) begin
      last_rev = rev;
      return V_DELTA;
    end
    return V_HEARTBEAT;
  endfunction

  function automatic sync_result_t predict_result();
    sync_result_t r;
    logic [TimeW-1:0] now;
    now       = upd_mon.now_us;
    r.verdict = V_NONE;
    if (cmd_e'(upd_mon.cmd) == CMD_UPDATE) begin
      heard      = 1'b1;
      heard_time = now;
      r.verdict  = judge_update(kind_e'(upd_mon.kind), upd_mon.session_tag,
                                upd_mon.seq_number, upd_mon.new_revision,
                                upd_mon.prior_revision, upd_mon.stamp_us);
    end else if (cmd_e'(upd_mon.cmd) == CMD_CLEAR) begin
      clear_tracking();
    end
    // a clock that went backwards counts as connected
    if (!heard) r.link_lost = 1'b1;
    else if (now < heard_time) r.link_lost = 1'b0;
    else r.link_lost = (now - heard_time) > TimeW'(timeout_us);
    r.in_sync       = synced;
    r.resync_needed = resync;
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned expv,
                             input logic [3:0] gotv);
    if ({28'd0, gotv} !== expv) begin
      $error("%s: expected %0d, got %0d", name, expv, gotv);
      err_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    sync_result_t exp_r;
    if (!rst_ni) begin
      clear_tracking();
      timeout_us  = TimeoutReset;
      expected_q.delete();
      err_count_o = 0;
      pending_o   = 0;
    end else begin
      if (cfg_we_i) timeout_us = cfg_wdata_i;
      // the result leaving now belongs to an older update, so compare first
      if (res_mon.valid && res_mon.ready) begin
        if (expected_q.size() == 0) begin
          $error("verdict: expected none pending, got %0d", res_mon.verdict);
          err_count_o++;
        end else begin
          exp_r = expected_q.pop_front();
          check_field("verdict", exp_r.verdict, res_mon.verdict);
          check_field("link_lost", exp_r.link_lost, {3'd0, res_mon.link_lost});
          check_field("in_sync", exp_r.in_sync, {3'd0, res_mon.in_sync});
          check_field("resync_needed", exp_r.resync_needed, {3'd0, res_mon.resync_needed});
        end
      end
      if (upd_mon.valid && upd_mon.ready) expected_q.push_back(predict_result());
      pending_o = expected_q.size();
    end
  end

endmodule

/* tb/tb_state_update_sync_checker.sv */
`timescale 1ns / 1ps
// top of the state update sync checker testbench: clock, reset, update stimulus,
// result back-pressure and verdict; depends on susc_pkg, the channel interfaces and susc_verdict_check
module tb_state_update_sync_checker;
  import susc_pkg::*;

  localparam int unsigned WatchdogLimit = 400;
  localparam int unsigned ItemsPerPhase = 190;
  localparam int unsigned NumPhases     = 5;
  localparam int unsigned DrainCycles   = 4;

  // one update as the sender sees it
  typedef struct {
    cmd_e              cmd;
    kind_e             kind;
    logic [SessW-1:0]  sess;
    logic [SeqW-1:0]   seq;
    logic [RevW-1:0]   rev;
    logic [RevW-1:0]   base;
    logic [StampW-1:0] stamp;
    logic [TimeW-1:0]  now;
  } update_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [TimeoutW-1:0] cfg_wdata_i;

  susc_in_if  in_ch ();
  susc_out_if out_ch ();

  int unsigned err_count;
  int unsigned pending_results;
  int unsigned quiet_cycles = 0;
  bit          no_idle = 1'b0;

  // sender-side picture of the stream, used to build mostly well-formed traffic
  logic [SessW-1:0]    tx_sess;
  logic [SeqW-1:0]     tx_seq;
  logic [RevW-1:0]     tx_rev;
  logic [StampW-1:0]   tx_stamp;
  logic [TimeW-1:0]    tx_now;
  logic [TimeoutW-1:0] tx_timeout;
  bit                  tx_desynced;

  state_update_sync_checker uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  susc_verdict_check verdict_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .upd_mon     (in_ch),
    .res_mon     (out_ch),
    .err_count_o (err_count),
    .pending_o   (pending_results)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // watchdog: too many cycles without any transaction ends the run
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WatchdogLimit) begin
      $display("tb_state_update_sync_checker: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side: random stall before each transaction, none in burst stretches
  initial begin
    int unsigned stall;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 15);
      if (stall != 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
      @(negedge clk_i);
    end
  end

  function automatic update_t upd(input cmd_e c, input kind_e k, input logic [SessW-1:0] s,
                                  input logic [SeqW-1:0] q, input logic [RevW-1:0] r, b,
                                  input logic [StampW-1:0] st, input logic [TimeW-1:0] n);
    update_t u;
    u.cmd   = c;
    u.kind  = k;
    u.sess  = s;
    u.seq   = q;
    u.rev   = r;
    u.base  = b;
    u.stamp = st;
    u.now   = n;
    return u;
  endfunction

  // called and returning at a falling edge; valid stays high across back-to-back items
  task automatic send_update(input update_t u);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid          = 1'b1;
    in_ch.cmd            = u.cmd;
    in_ch.kind           = u.kind;
    in_ch.session_tag    = u.sess;
    in_ch.seq_number     = u.seq;
    in_ch.new_revision   = u.rev;
    in_ch.prior_revision = u.base;
    in_ch.stamp_us       = u.stamp;
    in_ch.now_us         = u.now;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    while (pending_results != 0) @(negedge clk_i);
  endtask

  // timeout is only written with the block idle
  task automatic set_timeout(input logic [TimeoutW-1:0] value);
    in_ch.valid = 1'b0;
    wait_drained();
    repeat (DrainCycles) @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    tx_timeout  = value;
  endtask

  task automatic send_random_update();
    update_t     u;
    int unsigned pick;
    int unsigned tpick;

    // local time: mostly small steps, sometimes right at or past the timeout,
    // sometimes backwards, sometimes anywhere
    tpick = $urandom_range(0, 99);
    if (tpick < 80) tx_now = tx_now + $urandom_range(0, 40);
    else if (tpick < 90) tx_now = tx_now + tx_timeout + $urandom_range(0, 1);
    else if (tpick < 95) tx_now = tx_now - $urandom_range(1, 50);
    else tx_now = TimeW'({$urandom, $urandom});

    pick = $urandom_range(0, 99);
    // after a break in the stream, mostly recover with a snapshot
    if (tx_desynced && pick < 60 && $urandom_range(0, 3) != 0) pick = 60;

    tx_stamp = tx_stamp + $urandom_range(0, 500);
    u = upd(CMD_UPDATE, KIND_DELTA, tx_sess, tx_seq + 1, $urandom, tx_rev, tx_stamp, tx_now);

    if (pick < 45) begin
      // in-order delta
      tx_seq = u.seq;
      tx_rev = u.rev;
    end else if (pick < 60) begin
      // in-order heartbeat, both heartbeat encodings
      u.kind = $urandom_range(0, 1) ? KIND_HEARTBEAT : KIND_SPARE;
      tx_seq = u.seq;
    end else if (pick < 68) begin
      u.kind      = KIND_SNAPSHOT;
      u.seq       = tx_seq + $urandom_range(1, 3);
      tx_seq      = u.seq;
      tx_rev      = u.rev;
      tx_desynced = 1'b0;
    end else if (pick < 72) begin
      // repeat of the last sequence
      u.kind = kind_e'($urandom_range(0, 3));
      u.seq  = tx_seq;
    end else if (pick < 75) begin
      // older sequence or older timestamp
      if ($urandom_range(0, 1)) u.seq = tx_seq - $urandom_range(1, 10);
      else u.stamp = tx_stamp - $urandom_range(1, 600);
      u.kind = kind_e'($urandom_range(0, 3));
    end else if (pick < 79) begin
      // skipped sequence numbers
      u.seq       = tx_seq + $urandom_range(2, 9);
      u.kind      = $urandom_range(0, 1) ? KIND_DELTA : KIND_HEARTBEAT;
      tx_seq      = u.seq;
      tx_desynced = 1'b1;
    end else if (pick < 82) begin
      // delta against the wrong base revision
      u.base      = tx_rev ^ (32'd1 << $urandom_range(0, 31));
      tx_seq      = u.seq;
      tx_desynced = 1'b1;
    end else if (pick < 85) begin
      // switch to a fresh session
      tx_sess = $urandom;
      tx_seq  = $urandom;
      u.sess  = tx_sess;
      u.seq   = tx_seq;
      u.kind  = kind_e'($urandom_range(0, 3));
      if (u.kind == KIND_SNAPSHOT) begin
        tx_rev      = u.rev;
        tx_desynced = 1'b0;
      end else begin
        tx_desynced = 1'b1;
      end
    end else if (pick < 89) begin
      u.cmd = CMD_POLL;
    end else if (pick < 91) begin
      u.cmd = CMD_SPARE;
    end else if (pick < 93) begin
      u.cmd       = CMD_CLEAR;
      tx_desynced = 1'b1;
    end else begin
      // noise: any kind, any content
      u = upd(CMD_UPDATE, kind_e'($urandom_range(0, 3)),
              $urandom_range(0, 1) ? tx_sess : $urandom, $urandom, $urandom, $urandom,
              {$urandom, $urandom}, tx_now);
    end
    send_update(u);
  endtask

  initial begin
    logic [TimeoutW-1:0] phase_timeouts [NumPhases];
    logic [SessW-1:0]    sess_a;

    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_wdata_i          = '0;
    in_ch.valid          = 1'b0;
    in_ch.cmd            = CMD_UPDATE;
    in_ch.kind           = KIND_SNAPSHOT;
    in_ch.session_tag    = '0;
    in_ch.seq_number     = '0;
    in_ch.new_revision   = '0;
    in_ch.prior_revision = '0;
    in_ch.stamp_us       = '0;
    in_ch.now_us         = '0;
    tx_timeout           = TimeoutReset;
    sess_a               = 32'hA5A5_5A5A;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed part with a short timeout so both sides of the edge are easy to hit
    set_timeout(32'd100);
    send_update(upd(CMD_POLL, KIND_SNAPSHOT, '0, '0, '0, '0, '0, 48'd0));  // never heard
    send_update(upd(CMD_UPDATE, KIND_DELTA, sess_a, 32'd1, 32'd1, '0, 64'd10, 48'd10));
    send_update(upd(CMD_UPDATE, KIND_SNAPSHOT, sess_a, 32'd5, 32'd100, '0, 64'd1000, 48'd20));
    send_update(upd(CMD_UPDATE, KIND_DELTA, sess_a, 32'd6, 32'd101, 32'd100, 64'd1001, 48'd30));
    send_update(upd(CMD_UPDATE, KIND_HEARTBEAT, sess_a, 32'd7, '0, '0, 64'd1002, 48'd40));
    send_update(upd(CMD_UPDATE, KIND_SPARE, sess_a, 32'd8, '0, '0, 64'd1003, 48'd50));
    send_update(upd(CMD_UPDATE, KIND_DELTA, sess_a, 32'd8, 32'd7, 32'd101, 64'd1004, 48'd60));
    send_update(upd(CMD_UPDATE, KIND_DELTA, sess_a, 32'd3, 32'd7, 32'd101, 64'd1005, 48'd70));
    // newer sequence, older timestamp
    send_update(upd(CMD_UPDATE, KIND_DELTA, sess_a, 32'd9, 32'd102, 32'd101, 64'd5, 48'd100));
    send_update(upd(CMD_POLL, KIND_SNAPSHOT, '0, '0, '0, '0, '0, 48'd200));  // exactly timeout
    send_update(upd(CMD_POLL, KIND_SNAPSHOT, '0, '0, '0, '0, '0, 48'd201));  // one past
    send_update(upd(CMD_POLL, KIND_SNAPSHOT, '0, '0, '0, '0, '0, 48'd50));   // clock went back
    send_update(upd(CMD_UPDATE, KIND_DELTA, sess_a, 32'd9, 32'd102, 32'd999, 64'd1006, 48'd210));
    send_update(upd(CMD_UPDATE, KIND_DELTA, sess_a, 32'd10, 32'd103, 32'd102, 64'd1007, 48'd220));
    send_update(upd(CMD_UPDATE, KIND_SNAPSHOT, sess_a, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0,
                    64'hFFFF_FFFF_FFFF_FFFF, 48'd230));
    // sequence wraps to zero, which lands below the last one
    send_update(upd(CMD_UPDATE, KIND_DELTA, sess_a, 32'd0, 32'd1, 32'hFFFF_FFFF,
                    64'hFFFF_FFFF_FFFF_FFFF, 48'd240));
    send_update(upd(CMD_UPDATE, KIND_SNAPSHOT, 32'hFFFF_FFFF, 32'hFFFF_FFF0, '0, '0, '0,
                    48'd250));
    send_update(upd(CMD_UPDATE, KIND_DELTA, 32'hFFFF_FFFF, 32'hFFFF_FFF1, 32'd5, '0, 64'd1,
                    48'd260));
    send_update(upd(CMD_UPDATE, KIND_HEARTBEAT, 32'hFFFF_FFFF, 32'hFFFF_FFF5, '0, '0, 64'd2,
                    48'd270));
    send_update(upd(CMD_CLEAR, KIND_SNAPSHOT, '0, '0, '0, '0, '0, 48'd280));
    send_update(upd(CMD_SPARE, KIND_SNAPSHOT, '0, '0, '0, '0, '0, 48'd290));
    send_update(upd(CMD_UPDATE, KIND_SNAPSHOT, '0, '0, '0, '0, '0, 48'hFFFF_FFFF_FFFF));
    send_update(upd(CMD_POLL, KIND_SNAPSHOT, '0, '0, '0, '0, '0, 48'd0));
    send_update(upd(CMD_UPDATE, KIND_HEARTBEAT, 32'd5, 32'd1, '0, '0, 64'd3,
                    48'hFFFF_FFFF_FFFF));

    // random part: one timeout setting per phase, extremes included
    phase_timeouts[0] = 32'd0;
    phase_timeouts[1] = 32'hFFFF_FFFF;
    phase_timeouts[2] = TimeoutReset;
    phase_timeouts[3] = 32'd37;
    phase_timeouts[4] = $urandom;
    for (int p = 0; p < NumPhases; p++) begin
      set_timeout(phase_timeouts[p]);
      tx_sess     = $urandom;
      tx_seq      = $urandom;
      tx_rev      = $urandom;
      tx_stamp    = {$urandom_range(0, 32'h7FFF_FFFF), $urandom};
      tx_now      = (p % 2 == 0) ? TimeW'(0) : TimeW'({$urandom, $urandom});
      tx_desynced = 1'b1;
      for (int i = 0; i < ItemsPerPhase; i++) begin
        // back-to-back stretches on both sides
        no_idle = (i < 30) || (i >= 120 && i < 140);
        // let everything drain mid-phase, then resume
        if (i == 95) begin
          in_ch.valid = 1'b0;
          wait_drained();
        end
        send_random_update();
      end
      no_idle = 1'b0;
    end

    in_ch.valid = 1'b0;
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (err_count == 0) begin
      $display("tb_state_update_sync_checker: done, clean");
    end else begin
      $display("tb_state_update_sync_checker: done, errors");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/susc_pkg.sv
hw/rtl/susc_in_if.sv
hw/rtl/susc_out_if.sv
hw/rtl/state_update_sync_checker.sv
tb/susc_verdict_check.sv
tb/tb_state_update_sync_checker.sv
